// ===== sv/sitda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants
// Widths, character codes, queue entry and back-end state for the integer
// to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIGITS  = 10;                  // max decimal digits
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned CNT_W   = $clog2(VALUE_W);
  localparam int unsigned IDX_W   = $clog2(DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // one classified request: sign and unsigned magnitude
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } sitda_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_PREP,
    BK_EMIT
  } sitda_state_t;

endpackage

`default_nettype wire

// ===== sv/sitda_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_front: input classifier
// Accepts a request, splits it into sign and magnitude and pushes it on.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_front (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [31:0]             in_value,
  input  wire logic                           q_ready,
  output logic                                q_push,
  output sitda_pkg::sitda_entry_t             q_entry
);
  import sitda_pkg::*;

  logic [VALUE_W-1:0] raw;

  assign raw      = $unsigned(in_value);
  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // magnitude as unsigned, so the most negative value stays exact
  always_comb begin
    q_entry.neg = raw[VALUE_W-1];
    q_entry.mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
  end

endmodule

`default_nettype wire

// ===== sv/sitda_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_fifo: two-entry request queue
// Decouples the classifier from the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire sitda_pkg::sitda_entry_t push_entry,
  output logic                         not_full,
  input  wire logic                    pop,
  output sitda_pkg::sitda_entry_t      pop_entry,
  output logic                         not_empty
);
  import sitda_pkg::*;

  sitda_entry_t mem_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push, do_pop;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_push   = push & not_full;
  assign do_pop    = pop & not_empty;
  assign pop_entry = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r ^ do_push;
    rptr_nxt  = rptr_r ^ do_pop;
    count_nxt = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sitda_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_back: bcd converter and character emitter
// Shift-and-add-3 over the magnitude, then one character per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  input  wire sitda_pkg::sitda_entry_t q_entry,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [7:0]                   out_text_char,
  output logic                         out_last
);
  import sitda_pkg::*;

  sitda_state_t       state_r, state_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               sign_r, sign_nxt;
  logic [BCD_W-1:0]   adj;
  logic [3:0]         digit;
  logic               fire;

  // add 3 to every nibble of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? (bcd_r[4*d +: 4] + 4'd3)
                                                 : bcd_r[4*d +: 4];
    end
  end

  assign digit         = bcd_r[{idx_r, 2'b00} +: 4];
  assign out_valid     = (state_r == BK_EMIT);
  assign out_text_char = sign_r ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, digit});
  assign out_last      = !sign_r && (idx_r == '0);
  assign fire          = out_valid & out_ready;

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sign_nxt  = sign_r;
    q_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          bin_nxt   = q_entry.mag;
          sign_nxt  = q_entry.neg;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = BK_CONV;
        end
      end
      BK_CONV: begin
        bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          state_nxt = BK_PREP;
        end
      end
      BK_PREP: begin
        // highest nonzero digit; zero keeps a single digit
        idx_nxt = '0;
        for (int i = 0; i < DIGITS; i++) begin
          if (bcd_r[4*i +: 4] != 4'd0) begin
            idx_nxt = IDX_W'(i);
          end
        end
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (fire) begin
          if (sign_r) begin
            sign_nxt = 1'b0;
          end else if (idx_r == '0) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    sign_r <= sign_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed integer to decimal text
// Each request on the in_ channel is one two's complement value; the out_
// channel returns its text one character per handshake, a '-' for negative
// values, then the digits most significant first with no leading zeros.
// out_last marks the final character of each value.
// Steps: the back end takes a request off the queue, runs 32 steps of
// shift-and-add-3 in the bcd converter, one per magnitude bit, finds the
// leading digit, then emits one character per cycle while out_ready is
// high; a value has 1 to 11 characters. No new value starts until the last
// character is taken; the two-entry queue lets up to two further requests
// be taken while a value is converted or stalled. Reset empties the queue
// and returns the converter to idle. When out_ready is low the current
// character holds and the converter waits.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_text_char,
  output logic                    out_last
);
  import sitda_pkg::*;

  // classified request from the front, held in the queue for the back
  sitda_entry_t front_entry;
  sitda_entry_t queue_entry;
  logic         front_push;
  logic         queue_not_full;
  logic         queue_not_empty;
  logic         back_pop;

  // front: sign and magnitude split
  sitda_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .q_ready  (queue_not_full),
    .q_push   (front_push),
    .q_entry  (front_entry)
  );

  // queue between front and back
  sitda_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .push_entry (front_entry),
    .not_full   (queue_not_full),
    .pop        (back_pop),
    .pop_entry  (queue_entry),
    .not_empty  (queue_not_empty)
  );

  // back: bcd conversion and character output
  sitda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (queue_not_empty),
    .q_entry       (queue_entry),
    .q_pop         (back_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
